[hdl/lcdw_pkg.sv]
// shared types, codes and helpers of the character lcd command writer
package lcdw_pkg;

  localparam int LCDW_MAX_LINE_WIDTH = 40;

  // command codes
  localparam logic [3:0] REQ_CHAR     = 4'd0;
  localparam logic [3:0] REQ_CHAR_AT  = 4'd1;
  localparam logic [3:0] REQ_GOTO     = 4'd2;
  localparam logic [3:0] REQ_NEWLINE  = 4'd3;
  localparam logic [3:0] REQ_CLEAR    = 4'd4;
  localparam logic [3:0] REQ_HOME     = 4'd5;
  localparam logic [3:0] REQ_ENTRY    = 4'd6;
  localparam logic [3:0] REQ_DISPLAY  = 4'd7;
  localparam logic [3:0] REQ_SHIFT    = 4'd8;
  localparam logic [3:0] REQ_FUNCTION = 4'd9;
  localparam logic [3:0] REQ_CGRAM    = 4'd10;
  localparam logic [3:0] REQ_DDRAM    = 4'd11;
  localparam logic [3:0] REQ_INIT     = 4'd12;

  // configuration register indexes
  localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_BUS_8BIT   = 2'd1;
  localparam logic [1:0] CFG_TWO_LINES  = 2'd2;

  // controller instruction bytes
  localparam logic [7:0] INS_CLEAR    = 8'h01;
  localparam logic [7:0] INS_HOME     = 8'h02;
  localparam logic [7:0] INS_DISP_ON  = 8'h0C;
  localparam logic [7:0] INS_ENTRY_IN = 8'h06;
  localparam logic [7:0] INS_CUR_SHFT = 8'h10;
  localparam logic [7:0] WAKE_NIBBLE  = 8'h03;
  localparam logic [7:0] WAKE_LAST    = 8'h02;

  localparam int BYTES_MAX = 6;
  localparam int NB_W      = $clog2(BYTES_MAX + 1);
  localparam int BI_W      = $clog2(BYTES_MAX);
  localparam int PRE_LEN   = 4;
  localparam int PRE_W     = $clog2(PRE_LEN + 1);
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
  } lcdw_xfer_t;

  // one classified command: byte list, final cursor, init prefix flag
  typedef struct packed {
    lcdw_xfer_t [BYTES_MAX-1:0] xfers;
    logic [NB_W-1:0]            nbytes;
    logic                       init;
    logic [5:0]                 col;
    logic                       line;
  } lcdw_entry_t;

  typedef struct packed {
    logic [7:0] addr_cmd;
    logic [5:0] col;
    logic       line;
  } lcdw_pos_t;

  // cursor addressing: wrap past width, rows above 1 go home
  function automatic lcdw_pos_t lcdw_move(input logic [8:0] x, input logic [8:0] y,
                                          input logic [6:0] width);
    lcdw_pos_t  p;
    logic [8:0] xx;
    logic [8:0] yy;
    xx = x;
    yy = y;
    if (x >= {2'b00, width}) begin
      yy = y + 9'd1;
      xx = '0;
    end
    if (yy == 9'd0) begin
      p.line = 1'b0;
    end else if (yy == 9'd1) begin
      p.line = 1'b1;
    end else begin
      p.line = 1'b0;
      xx = '0;
    end
    p.col = xx[5:0];
    p.addr_cmd = {1'b1, p.line, xx[5:0]};
    return p;
  endfunction

endpackage

[hdl/lcdw_front.sv]
// front end: takes commands, tracks the cursor, builds the byte list
module lcdw_front import lcdw_pkg::*; #(
  parameter int MAX_LINE_WIDTH = LCDW_MAX_LINE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // char_code, col, row, opt_a, opt_b, opt_c, ram_addr, pad
  input  logic [3:0]  s_tuser,   // req_type
  input  logic [5:0]  line_width,
  input  logic        bus_8bit,
  input  logic        two_lines,
  input  logic        q_full,
  output logic        push,
  output lcdw_entry_t push_entry
);

  localparam logic [6:0] MaxWidth = 7'(MAX_LINE_WIDTH);

  logic [5:0] cur_col;
  logic       cur_line;
  logic [6:0] eff_width;
  logic       known_code;
  logic       accept;
  lcdw_pos_t  p1;
  lcdw_pos_t  p2;
  lcdw_pos_t  pc;
  lcdw_pos_t  pn;

  logic [7:0] char_code;
  logic [7:0] col;
  logic [7:0] row;
  logic       opt_a;
  logic       opt_b;
  logic       opt_c;
  logic [6:0] ram_addr;

  assign char_code = s_tdata[7:0];
  assign col       = s_tdata[15:8];
  assign row       = s_tdata[23:16];
  assign opt_a     = s_tdata[24];
  assign opt_b     = s_tdata[25];
  assign opt_c     = s_tdata[26];
  assign ram_addr  = s_tdata[33:27];

  assign eff_width = ({1'b0, line_width} > MaxWidth) ? MaxWidth : {1'b0, line_width};

  assign p1 = lcdw_move({1'b0, col}, {1'b0, row}, eff_width);
  assign p2 = lcdw_move({3'b000, p1.col} + 9'd1, {8'h00, p1.line}, eff_width);
  assign pc = lcdw_move({3'b000, cur_col} + 9'd1, {8'h00, cur_line}, eff_width);
  assign pn = lcdw_move(9'd0, {8'h00, cur_line} + 9'd1, eff_width);

  always_comb begin
    push_entry = '0;
    push_entry.col = cur_col;
    push_entry.line = cur_line;
    known_code = 1'b1;
    unique case (s_tuser)
      REQ_CHAR: begin
        push_entry.xfers[0] = '{rs: 1'b1, data: char_code};
        push_entry.xfers[1] = '{rs: 1'b0, data: pc.addr_cmd};
        push_entry.nbytes = NB_W'(2);
        push_entry.col = pc.col;
        push_entry.line = pc.line;
      end
      REQ_CHAR_AT: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: p1.addr_cmd};
        push_entry.xfers[1] = '{rs: 1'b1, data: char_code};
        push_entry.xfers[2] = '{rs: 1'b0, data: p2.addr_cmd};
        push_entry.nbytes = NB_W'(3);
        push_entry.col = p2.col;
        push_entry.line = p2.line;
      end
      REQ_GOTO: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: p1.addr_cmd};
        push_entry.nbytes = NB_W'(1);
        push_entry.col = p1.col;
        push_entry.line = p1.line;
      end
      REQ_NEWLINE: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: pn.addr_cmd};
        push_entry.nbytes = NB_W'(1);
        push_entry.col = pn.col;
        push_entry.line = pn.line;
      end
      REQ_CLEAR: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: INS_CLEAR};
        push_entry.nbytes = NB_W'(1);
        push_entry.col = '0;
        push_entry.line = 1'b0;
      end
      REQ_HOME: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: INS_HOME};
        push_entry.nbytes = NB_W'(1);
        push_entry.col = '0;
        push_entry.line = 1'b0;
      end
      REQ_ENTRY: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: {5'b00001, opt_a, opt_b}};
        push_entry.nbytes = NB_W'(1);
      end
      REQ_DISPLAY: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: {4'b0000, 1'b1, opt_a, opt_b, opt_c}};
        push_entry.nbytes = NB_W'(1);
      end
      REQ_SHIFT: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: {4'b0001, opt_a, opt_b, 2'b00}};
        push_entry.nbytes = NB_W'(1);
      end
      REQ_FUNCTION: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: {3'b001, opt_a, opt_b, opt_c, 2'b00}};
        push_entry.nbytes = NB_W'(1);
      end
      REQ_CGRAM: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: {2'b01, ram_addr[5:0]}};
        push_entry.nbytes = NB_W'(1);
      end
      REQ_DDRAM: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: {1'b1, ram_addr}};
        push_entry.nbytes = NB_W'(1);
      end
      REQ_INIT: begin
        push_entry.xfers[0] = '{rs: 1'b0, data: {3'b001, bus_8bit, two_lines, 3'b000}};
        push_entry.xfers[1] = '{rs: 1'b0, data: INS_DISP_ON};
        push_entry.xfers[2] = '{rs: 1'b0, data: INS_ENTRY_IN};
        push_entry.xfers[3] = '{rs: 1'b0, data: INS_CUR_SHFT};
        push_entry.xfers[4] = '{rs: 1'b0, data: INS_CLEAR};
        push_entry.xfers[5] = '{rs: 1'b0, data: INS_HOME};
        push_entry.nbytes = NB_W'(BYTES_MAX);
        push_entry.init = 1'b1;
        push_entry.col = '0;
        push_entry.line = 1'b0;
      end
      default: begin
        known_code = 1'b0;
      end
    endcase
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && known_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_line <= 1'b0;
    end else if (push) begin
      cur_col  <= push_entry.col;
      cur_line <= push_entry.line;
    end
  end

endmodule

[hdl/lcdw_queue.sv]
// short command queue between front end and bus sequencer
module lcdw_queue import lcdw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lcdw_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output lcdw_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LastPtr  = PTR_W'(DEPTH - 1);

  lcdw_entry_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full  = (count == DepthCnt);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= DepthCnt;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue count past depth");

  property p_no_overflow;
    @(posedge clk) disable iff (rst) full |-> !push;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("push into full queue");

  property p_no_underflow;
    @(posedge clk) disable iff (rst) empty |-> !pop;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("pop from empty queue");

endmodule

[hdl/lcdw_back.sv]
// bus sequencer: splits queued commands into bus transfers
module lcdw_back import lcdw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        bus_8bit,
  input  logic        q_empty,
  input  lcdw_entry_t head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // bus_value, cursor_col, cursor_row, pad
  output logic        m_tuser,   // reg_select
  output logic        m_tlast
);

  localparam logic [PRE_W-1:0] PreDone = PRE_W'(PRE_LEN);
  localparam logic [PRE_W-1:0] PreLast = PRE_W'(PRE_LEN - 1);

  logic [PRE_W-1:0] pre_cnt;
  logic [BI_W-1:0]  bi;
  logic             lo;
  logic             in_prefix;
  logic             emit;
  logic             last_xfer;
  logic             xfer_rs;
  logic [7:0]       xfer_val;
  lcdw_xfer_t       cur;

  assign in_prefix = head.init && !bus_8bit && (pre_cnt != PreDone);
  assign cur       = head.xfers[bi];
  assign last_xfer = !in_prefix && (NB_W'(bi) == (head.nbytes - NB_W'(1)))
                     && (bus_8bit || lo);
  assign emit      = !q_empty && (!m_tvalid || m_tready);
  assign pop       = emit && last_xfer;

  always_comb begin
    if (in_prefix) begin
      xfer_rs  = 1'b0;
      xfer_val = (pre_cnt == PreLast) ? WAKE_LAST : WAKE_NIBBLE;
    end else if (bus_8bit) begin
      xfer_rs  = cur.rs;
      xfer_val = cur.data;
    end else begin
      xfer_rs  = cur.rs;
      xfer_val = lo ? {4'h0, cur.data[3:0]} : {4'h0, cur.data[7:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_cnt  <= '0;
      bi       <= '0;
      lo       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (emit) begin
        if (last_xfer) begin
          pre_cnt <= '0;
          bi      <= '0;
          lo      <= 1'b0;
        end else if (in_prefix) begin
          pre_cnt <= pre_cnt + PRE_W'(1);
        end else if (!bus_8bit && !lo) begin
          lo <= 1'b1;
        end else begin
          lo <= 1'b0;
          bi <= bi + BI_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {1'b0, head.line, head.col, xfer_val};
      m_tuser <= xfer_rs;
      m_tlast <= last_xfer;
    end
  end

  property p_restart;
    @(posedge clk) disable iff (rst) pop |=> (bi == '0 && !lo && pre_cnt == '0);
  endproperty
  a_restart: assert property (p_restart) else $error("sequencer not rewound after command");

  property p_byte_index;
    @(posedge clk) disable iff (rst) !q_empty |-> (NB_W'(bi) < head.nbytes);
  endproperty
  a_byte_index: assert property (p_byte_index) else $error("byte index past command length");

  property p_prefix_bound;
    @(posedge clk) disable iff (rst) pre_cnt <= PreDone;
  endproperty
  a_prefix_bound: assert property (p_prefix_bound) else $error("wake-up count overrun");

endmodule

[hdl/char_lcd_command_writer.sv]
// top level of the character lcd command writer
// Each accepted command item of a known type turns into the bus transfers a
// two-line character lcd controller needs, one output item per transfer, with tlast
// on the final transfer of the command and the cursor position after the whole
// command on every transfer. Most commands have one or two transfers, char_at has up
// to six, and init on a 4-bit bus has sixteen (four wake-up nibbles plus six bytes as
// nibble pairs). The back-end sequencer emits one transfer per cycle, while the output
// is not stalled, from the head of a two-entry command queue; the front end classifies
// a command per cycle and tracks the cursor, so it keeps taking items while the queue
// has room. Configuration writes are always ready and belong in idle periods only.
module char_lcd_command_writer import lcdw_pkg::*; #(
  parameter int MAX_LINE_WIDTH = LCDW_MAX_LINE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // command input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // char_code[7:0], col[15:8], row[23:16], opt_a[24],
                                 // opt_b[25], opt_c[26], ram_addr[33:27], zero pad
  input  logic [3:0]  s_tuser,   // req_type
  // bus transfer output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // bus_value[7:0], cursor_col[13:8], cursor_row[14], zero pad
  output logic        m_tuser,   // reg_select
  output logic        m_tlast,   // last transfer of the command
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  // config registers
  logic [5:0]  line_width;
  logic        bus_8bit;
  logic        two_lines;

  // front to queue
  logic        push;
  lcdw_entry_t push_entry;
  // queue to back
  logic        q_full;
  logic        q_empty;
  logic        pop;
  lcdw_entry_t head;

  // writes are registered, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 6'd16;
      bus_8bit   <= 1'b0;
      two_lines  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_WIDTH: line_width <= cfg_data;
        CFG_BUS_8BIT:   bus_8bit   <= cfg_data[0];
        CFG_TWO_LINES:  two_lines  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // classify commands and track the cursor
  lcdw_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .line_width (line_width),
    .bus_8bit   (bus_8bit),
    .two_lines  (two_lines),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples classification from transfer sequencing
  lcdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  // one bus transfer per cycle into the output register while a command is queued and the output is not stalled
  lcdw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .bus_8bit (bus_8bit),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
